// ===== src/dmwo_pkg.sv =====
// Shared types, constants and tables of the drive mode / watchdog / odometry unit.
package dmwo_pkg;

	typedef enum logic [2:0] {
		MODE_STOP     = 3'd0,
		MODE_FORWARD  = 3'd1,
		MODE_BACKWARD = 3'd2,
		MODE_LEFT     = 3'd3,
		MODE_RIGHT    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CMD_VELOCITY = 2'd0,
		CMD_MANUAL   = 2'd1,
		CMD_WATCHDOG = 2'd2,
		CMD_PUBLISH  = 2'd3
	} cmd_t;

	localparam logic [2:0] MAN_STOP    = 3'd0;
	localparam logic [2:0] MAN_FORWARD = 3'd1;
	localparam logic [2:0] MAN_LEFT    = 3'd2;
	localparam logic [2:0] MAN_RIGHT   = 3'd3;

	localparam logic [2:0] REG_DEADBAND = 3'd0;
	localparam logic [2:0] REG_FWD_SPD  = 3'd1;
	localparam logic [2:0] REG_TURN     = 3'd2;
	localparam logic [2:0] REG_WDG_TO   = 3'd3;
	localparam logic [2:0] REG_GRACE    = 3'd4;

	localparam logic signed [19:0] PI_Q13      = 20'sd25736;
	localparam logic signed [19:0] TWO_PI_Q13  = 20'sd51472;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [19:0] PI_Q16      = 20'sd205887;
	localparam logic signed [19:0] CORDIC_GAIN = 20'sd9949;
	localparam logic [9:0]         DT_MAX      = 10'd1000;
	// round(n / 1024000): add half of 1024000, drop 10 bits, then multiply by
	// ceil(2^38 / 1000) and drop 38 bits (exact for the 31-bit operand)
	localparam logic [19:0]        HALF_DIV    = 20'd512000;
	localparam logic [28:0]        RECIP_1000  = 29'd274877907;
	// heading divides by 500 = 1024000 / 2^11, so scale it onto the same divider
	localparam int                 HEAD_SHIFT  = 11;
	localparam int                 MAX_STEPS   = 20;

	typedef struct packed {
		logic [11:0] deadband;
		logic [14:0] forward_speed;
		logic [14:0] turn_rate;
		logic [15:0] watchdog_timeout_ms;
		logic [15:0] manual_grace_ms;
	} cfg_t;

	typedef struct packed {
		cmd_t               command;
		logic [31:0]        time_ms;
		logic signed [15:0] lin_vel;
		logic signed [15:0] ang_vel;
		logic [2:0]         manual_code;
	} req_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [15:0] drive_linear;
		logic signed [15:0] drive_angular;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic               watchdog_fired;
	} res_t;

	function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
		logic signed [19:0] v;
		case (i)
			5'd0:  v = 20'sd51472;
			5'd1:  v = 20'sd30385;
			5'd2:  v = 20'sd16055;
			5'd3:  v = 20'sd8150;
			5'd4:  v = 20'sd4091;
			5'd5:  v = 20'sd2047;
			5'd6:  v = 20'sd1024;
			5'd7:  v = 20'sd512;
			5'd8:  v = 20'sd256;
			5'd9:  v = 20'sd128;
			5'd10: v = 20'sd64;
			5'd11: v = 20'sd32;
			5'd12: v = 20'sd16;
			5'd13: v = 20'sd8;
			5'd14: v = 20'sd4;
			5'd15: v = 20'sd2;
			5'd16: v = 20'sd1;
			5'd17: v = 20'sd1;
			default: v = 20'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/dmwo_front.sv =====
// Request intake: classifies the command and buffers requests in a two-entry queue.
module dmwo_front import dmwo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_cmd,
	input  logic [66:0] in_data,
	output logic        q_valid,
	output req_t        q_req,
	input  logic        q_pop
);

	req_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	req_t       req;
	logic       push;

	always_comb begin
		req.command     = cmd_t'(in_cmd);
		req.time_ms     = in_data[31:0];
		req.lin_vel     = in_data[47:32];
		req.ang_vel     = in_data[63:48];
		req.manual_code = in_data[66:64];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== src/dmwo_back.sv =====
// Execution engine: mode logic, watchdog, CORDIC and reciprocal rounding divider for odometry.
module dmwo_back import dmwo_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_valid,
	input  req_t q_req,
	output logic q_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_ready
);

	localparam int          N_IT   = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
	localparam logic [4:0]  LAST_IT = 5'(N_IT - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CORD, S_MULA, S_MULB, S_DIVI, S_DIV, S_APPLY, S_WRAP
	} st_t;

	st_t                st_q;
	mode_t              mode_q;
	logic [31:0]        lastcmd_q, lastpub_q;
	logic signed [31:0] px_q, py_q;
	logic signed [15:0] hd_q;
	logic [9:0]         dt_q;
	logic signed [15:0] lin_q, ang_q;
	logic signed [19:0] cx_q, cy_q, z_q;
	logic               flip_q, neg_q;
	logic [4:0]         cnt_q;
	logic [1:0]         k_q;
	logic signed [35:0] prod_q;
	logic signed [47:0] full_q;
	logic [30:0]        num_q;
	logic [21:0]        quo_q;
	logic signed [18:0] h_q;
	logic               ov_q;
	res_t               res_q;

	logic               out_free;
	logic               emit_cmd, emit_pub;
	mode_t              nmode;
	logic               fire;
	logic [16:0]        al, aa;
	logic [31:0]        wd;
	logic signed [15:0] dl, da;
	logic [31:0]        dtraw;
	logic signed [19:0] z0, c_v, s_v;
	logic signed [19:0] xs, ys;
	logic [47:0]        mag;
	logic [47:0]        rnd;
	logic [59:0]        qm;
	logic [31:0]        rv;

	assign out_free  = !ov_q || res_ready;
	assign q_pop     = (st_q == S_IDLE) && q_valid && out_free;
	assign emit_cmd  = q_pop && (q_req.command != CMD_PUBLISH);
	assign emit_pub  = (st_q == S_WRAP) && h_q <= 19'(PI_Q13) && h_q >= -19'(PI_Q13)
	                   && out_free;
	assign res_valid = ov_q;
	assign res       = res_q;

	// next mode for non-publish requests
	always_comb begin
		nmode = mode_q;
		fire  = 1'b0;
		al    = q_req.lin_vel[15] ? 17'(-{q_req.lin_vel[15], q_req.lin_vel})
		                          : {1'b0, q_req.lin_vel};
		aa    = q_req.ang_vel[15] ? 17'(-{q_req.ang_vel[15], q_req.ang_vel})
		                          : {1'b0, q_req.ang_vel};
		wd    = q_req.time_ms - lastcmd_q;
		unique case (q_req.command)
			CMD_VELOCITY: begin
				if (al > {5'd0, cfg.deadband} && al > aa) begin
					nmode = q_req.lin_vel[15] ? MODE_BACKWARD : MODE_FORWARD;
				end else if (aa > {5'd0, cfg.deadband} && al <= aa) begin
					nmode = q_req.ang_vel[15] ? MODE_RIGHT : MODE_LEFT;
				end else begin
					nmode = MODE_STOP;
				end
			end
			CMD_MANUAL: begin
				case (q_req.manual_code)
					MAN_STOP:    nmode = MODE_STOP;
					MAN_FORWARD: nmode = MODE_FORWARD;
					MAN_LEFT:    nmode = MODE_LEFT;
					MAN_RIGHT:   nmode = MODE_RIGHT;
					default:     nmode = mode_q;
				endcase
			end
			CMD_WATCHDOG: begin
				if (!wd[31] && wd > {16'd0, cfg.watchdog_timeout_ms} && mode_q != MODE_STOP) begin
					nmode = MODE_STOP;
					fire  = 1'b1;
				end
			end
			default: nmode = mode_q;
		endcase
	end

	// drive speeds of the mode that stands at emission
	always_comb begin
		mode_t m;
		m  = (st_q == S_IDLE) ? nmode : mode_q;
		dl = 16'sd0;
		da = 16'sd0;
		unique case (m)
			MODE_FORWARD:  dl = $signed({1'b0, cfg.forward_speed});
			MODE_BACKWARD: dl = -$signed({1'b0, cfg.forward_speed});
			MODE_LEFT:     da = $signed({1'b0, cfg.turn_rate});
			MODE_RIGHT:    da = -$signed({1'b0, cfg.turn_rate});
			default: ;
		endcase
	end

	always_comb begin
		dtraw = q_req.time_ms - lastpub_q;
		z0    = 20'(hd_q) <<< 3;
		c_v   = flip_q ? -cx_q : cx_q;
		s_v   = flip_q ? -cy_q : cy_q;
		xs    = cx_q >>> cnt_q;
		ys    = cy_q >>> cnt_q;
		mag   = full_q[47] ? 48'(-full_q) : 48'(full_q);
		rnd   = mag + 48'(HALF_DIV);
		qm    = {29'd0, num_q} * {31'd0, RECIP_1000};
		rv    = neg_q ? -{10'd0, quo_q} : {10'd0, quo_q};
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && q_pop && q_req.command == CMD_PUBLISH) begin
			dt_q  <= (dtraw > {22'd0, DT_MAX}) ? DT_MAX : dtraw[9:0];
			lin_q <= dl;
			ang_q <= da;
			cx_q  <= CORDIC_GAIN;
			cy_q  <= 20'sd0;
			cnt_q <= 5'd0;
			k_q   <= 2'd0;
			if (z0 > HALF_PI_Q16) begin
				z_q    <= z0 - PI_Q16;
				flip_q <= 1'b1;
			end else if (z0 < -HALF_PI_Q16) begin
				z_q    <= z0 + PI_Q16;
				flip_q <= 1'b1;
			end else begin
				z_q    <= z0;
				flip_q <= 1'b0;
			end
		end
		case (st_q)
			S_CORD: begin
				cnt_q <= cnt_q + 5'd1;
				if (!z_q[19]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - atan_q16(cnt_q);
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + atan_q16(cnt_q);
				end
			end
			S_MULA: begin
				case (k_q)
					2'd0:    prod_q <= 36'(lin_q * c_v);
					2'd1:    prod_q <= 36'(lin_q * s_v);
					default: prod_q <= 36'(ang_q) <<< HEAD_SHIFT;
				endcase
			end
			S_MULB: full_q <= 48'(prod_q * $signed({1'b0, dt_q}));
			S_DIVI: begin
				neg_q <= full_q[47];
				num_q <= rnd[40:10];
			end
			S_DIV: quo_q <= qm[59:38];
			S_APPLY: begin
				k_q <= k_q + 2'd1;
				h_q <= 19'(hd_q) + $signed(rv[18:0]);
			end
			S_WRAP: begin
				if (h_q > 19'(PI_Q13)) begin
					h_q <= h_q - 19'(TWO_PI_Q13);
				end else if (h_q < -19'(PI_Q13)) begin
					h_q <= h_q + 19'(TWO_PI_Q13);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			mode_q    <= MODE_STOP;
			lastcmd_q <= 32'd0;
			lastpub_q <= 32'd0;
			px_q      <= 32'sd0;
			py_q      <= 32'sd0;
			hd_q      <= 16'sd0;
			ov_q      <= 1'b0;
			res_q     <= '0;
		end else begin
			if (emit_cmd || emit_pub) begin
				ov_q <= 1'b1;
			end else if (res_ready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_req.command == CMD_PUBLISH) begin
							lastpub_q <= q_req.time_ms;
							st_q      <= S_CORD;
						end else begin
							mode_q <= nmode;
							if (q_req.command == CMD_VELOCITY) begin
								lastcmd_q <= q_req.time_ms;
							end else if (q_req.command == CMD_MANUAL) begin
								lastcmd_q <= q_req.time_ms + {16'd0, cfg.manual_grace_ms};
							end
							res_q.mode           <= nmode;
							res_q.drive_linear   <= dl;
							res_q.drive_angular  <= da;
							res_q.pos_x          <= px_q;
							res_q.pos_y          <= py_q;
							res_q.heading        <= hd_q;
							res_q.watchdog_fired <= fire;
						end
					end
				end
				S_CORD:  st_q <= (cnt_q == LAST_IT) ? S_MULA : S_CORD;
				S_MULA:  st_q <= S_MULB;
				S_MULB:  st_q <= S_DIVI;
				S_DIVI:  st_q <= S_DIV;
				S_DIV:   st_q <= S_APPLY;
				S_APPLY: begin
					case (k_q)
						2'd0: begin
							px_q <= px_q + $signed(rv);
							st_q <= S_MULA;
						end
						2'd1: begin
							py_q <= py_q + $signed(rv);
							st_q <= S_MULA;
						end
						default: st_q <= S_WRAP;
					endcase
				end
				S_WRAP: begin
					if (emit_pub) begin
						hd_q                 <= h_q[15:0];
						res_q.mode           <= mode_q;
						res_q.drive_linear   <= dl;
						res_q.drive_angular  <= da;
						res_q.pos_x          <= px_q;
						res_q.pos_y          <= py_q;
						res_q.heading        <= h_q[15:0];
						res_q.watchdog_fired <= 1'b0;
						st_q                 <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/drive_mode_watchdog_odometry_unit.sv =====
// Top level of the drive mode controller with watchdog and dead-reckoning odometry.
// Every request gives exactly one result carrying the mode, the drive speeds of that mode,
// the pose and the watchdog flag. Velocity, manual and watchdog requests are handled as
// soon as they leave the queue; their result is registered as they are popped. A publish
// request integrates the pose: it runs an iterative CORDIC of min(CORDIC_STEPS,20)
// iterations, then for x, y and heading in turn two multiply steps, a rounding step, a
// reciprocal-multiply step and an apply step, then heading wrap steps until the heading
// lies within +-pi and the result register is free or draining; then the result is
// registered. A two-entry request queue sits between intake and execution and keeps
// accepting requests while a result waits; the engine takes the next request once the
// result register is free or draining. The user must write configuration registers
// through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module drive_mode_watchdog_odometry_unit import dmwo_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,  // command
	input  logic [71:0]  s_tdata,  // time_ms, lin_vel, ang_vel, manual_code, zero fill
	output logic         m_tvalid,
	input  logic         m_tready,
	// mode, drive_linear, drive_angular, pos_x, pos_y, heading, watchdog_fired, zero fill
	output logic [119:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cfg_t cfg_q;
	logic q_valid, q_pop;
	req_t q_req;
	res_t res;

	// hold configuration registers; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband            <= 12'd4;
			cfg_q.forward_speed       <= 15'd2048;
			cfg_q.turn_rate           <= 15'd3277;
			cfg_q.watchdog_timeout_ms <= 16'd200;
			cfg_q.manual_grace_ms     <= 16'd2000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEADBAND: cfg_q.deadband            <= cfg_data[11:0];
				REG_FWD_SPD:  cfg_q.forward_speed       <= cfg_data[14:0];
				REG_TURN:     cfg_q.turn_rate           <= cfg_data[14:0];
				REG_WDG_TO:   cfg_q.watchdog_timeout_ms <= cfg_data;
				REG_GRACE:    cfg_q.manual_grace_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	dmwo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_data  (s_tdata[66:0]),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	dmwo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	assign m_tdata = {4'd0, res.watchdog_fired, res.heading, res.pos_y, res.pos_x,
		res.drive_angular, res.drive_linear, res.mode};

	a_fire_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[115] |-> m_tdata[2:0] == MODE_STOP)
		else $error("watchdog fired but mode is not STOP");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[114:99]) <= 16'sd25736 &&
		              $signed(m_tdata[114:99]) >= -16'sd25736))
		else $error("heading out of range");

	a_lin_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18:3] != 16'd0 |->
		(m_tdata[2:0] == MODE_FORWARD || m_tdata[2:0] == MODE_BACKWARD))
		else $error("linear speed in a mode without linear drive");

endmodule
